FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lease lock table check failed");

// Concurrent assertion on the project clock and reset names.
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/core/llt_pkg.sv
// Shared types and constants of the lease lock table.
`default_nettype none

package llt_pkg;

  // Table geometry and field widths.
  localparam int NUM_LOCKS = 256;
  localparam int LOCK_W    = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int PTR_W     = LOCK_W + 1;
  localparam int CLIENT_W  = 16;
  localparam int AGE_W     = 16;
  localparam int OPC_W     = 2;
  localparam int STAT_W    = 2;
  localparam int INDEX_W   = 8;

  // Reset value of the lease lifetime register.
  localparam logic [AGE_W-1:0] LIFETIME_RST = AGE_W'(10);

  // Request codes.
  typedef enum logic [OPC_W-1:0] {
    OP_ACQUIRE   = 2'd0,
    OP_RELEASE   = 2'd1,
    OP_HEARTBEAT = 2'd2,
    OP_TICK      = 2'd3
  } op_e;

  // Result codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BUSY  = 2'd2;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic                held;
    logic [CLIENT_W-1:0] owner;
    logic [AGE_W-1:0]    age;
  } entry_t;

  // Write request from the control logic to the entry store.
  typedef struct packed {
    logic              en;
    logic [LOCK_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/llt_store.sv
// Lock entry store: memory with a registered read port plus per-entry known bits.
`default_nettype none

module llt_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [llt_pkg::LOCK_W-1:0] rd_addr_i,
  input  llt_pkg::wr_req_t          wr_i,
  output logic                      rd_known_o,
  output llt_pkg::entry_t           rd_entry_o
);
  import llt_pkg::*;

  entry_t               mem_q [NUM_LOCKS];
  entry_t               rd_data_q;
  logic [NUM_LOCKS-1:0] known_q;
  logic                 rd_known_q;

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // Known bits are cleared by reset; any write marks its entry known.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q    <= '0;
      rd_known_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        known_q[wr_i.addr] <= 1'b1;
      end
      rd_known_q <= known_q[rd_addr_i];
    end
  end

  // An entry never written reads as all zeros.
  assign rd_known_o = rd_known_q;
  assign rd_entry_o = rd_known_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/lease_lock_table_top.sv
// Lease lock table: request decode, read-modify-write control and tick sweep.
//
// A lock request (acquire, release, heartbeat) reads its entry from the memory
// at the accept edge and writes any change back as S_REQ ends. The one-cycle result
// strobe done_o follows in the next cycle, which is also the first cycle in
// which busy is low again, so a new request is taken only after the last result.
// A tick sweeps every entry, from lock 0 upward, through the store's read and
// write ports: busy stays high until the last entry has been written back, and
// the next transfer can be accepted once busy is low. Results cannot be held off:
// each is flagged by done_o for a single cycle, and status_o holds it until the
// next result. The table needs no clearing pass after reset.
`default_nettype none

module lease_lock_table_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [llt_pkg::OPC_W-1:0]    opcode_i,
  input  logic [llt_pkg::CLIENT_W-1:0] client_id_i,
  input  logic [llt_pkg::INDEX_W-1:0]  lock_index_i,
  input  logic                        lease_lifetime_we_i,
  input  logic [llt_pkg::AGE_W-1:0]    lease_lifetime_i,
  output logic                        done_o,
  output logic [llt_pkg::STAT_W-1:0]   status_o
);
  import llt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REQ,
    S_TICK
  } state_e;

  state_e              state_q;
  op_e                 op_q;
  logic [CLIENT_W-1:0] client_q;
  logic                in_range_q;
  logic [LOCK_W-1:0]   addr_q;
  logic [PTR_W-1:0]    ptr_q;
  logic [AGE_W-1:0]    lifetime_q;
  logic                done_q;
  logic [STAT_W-1:0]   status_q;

  logic [LOCK_W-1:0]   rd_addr;
  wr_req_t             wr;
  logic                rd_known;
  entry_t              rd_entry;
  logic                owner_match;
  logic                tick_last;
  logic [STAT_W-1:0]   req_status;
  logic                accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // Read address: the request's lock in the accept cycle (lock 0 for a tick),
  // the sweep pointer otherwise.
  assign rd_addr   = (state_q != S_IDLE)              ? ptr_q[LOCK_W-1:0] :
                     (op_e'(opcode_i) == OP_TICK)     ? '0 :
                                                        LOCK_W'(lock_index_i);
  assign tick_last = (ptr_q == PTR_W'(NUM_LOCKS));

  llt_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .wr_i       (wr),
    .rd_known_o (rd_known),
    .rd_entry_o (rd_entry)
  );

  assign owner_match = (rd_entry.owner == client_q);

  // Modify step: decide the status and the write-back for the entry just read.
  always_comb begin
    wr         = '0;
    wr.addr    = addr_q;
    wr.data    = rd_entry;
    req_status = ST_OK;
    unique case (state_q)
      S_REQ: begin
        unique case (op_q)
          OP_ACQUIRE: begin
            if (!in_range_q) begin
              req_status = ST_NOENT;
            end else if (rd_entry.held) begin
              req_status = ST_BUSY;
            end else begin
              wr.en         = 1'b1;
              wr.data.held  = 1'b1;
              wr.data.owner = client_q;
              wr.data.age   = '0;
            end
          end
          OP_RELEASE: begin
            if (!in_range_q || !rd_known) begin
              req_status = ST_NOENT;
            end else if (owner_match) begin
              wr.en        = 1'b1;
              wr.data.held = 1'b0;
            end
          end
          OP_HEARTBEAT: begin
            if (in_range_q && rd_entry.held && owner_match) begin
              wr.en       = 1'b1;
              wr.data.age = '0;
            end
          end
          default: begin
            req_status = ST_OK;
          end
        endcase
      end
      S_TICK: begin
        if (rd_entry.held) begin
          wr.en = 1'b1;
          if (rd_entry.age >= lifetime_q) begin
            wr.data.held = 1'b0;
          end else begin
            wr.data.age = AGE_W'(rd_entry.age + 1'b1);
          end
        end
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  // Control state, request capture and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_ACQUIRE;
      client_q   <= '0;
      in_range_q <= 1'b0;
      addr_q     <= '0;
      ptr_q      <= '0;
      lifetime_q <= LIFETIME_RST;
      done_q     <= 1'b0;
      status_q   <= ST_OK;
    end else begin
      done_q <= 1'b0;
      if (lease_lifetime_we_i) begin
        lifetime_q <= lease_lifetime_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q       <= op_e'(opcode_i);
            client_q   <= client_id_i;
            in_range_q <= (32'(lock_index_i) < NUM_LOCKS);
            addr_q     <= rd_addr;
            ptr_q      <= PTR_W'(1);
            state_q    <= (op_e'(opcode_i) == OP_TICK) ? S_TICK : S_REQ;
          end
        end
        S_REQ: begin
          done_q   <= 1'b1;
          status_q <= req_status;
          state_q  <= S_IDLE;
        end
        S_TICK: begin
          if (tick_last) begin
            done_q   <= 1'b1;
            status_q <= ST_OK;
            state_q  <= S_IDLE;
          end else begin
            addr_q <= ptr_q[LOCK_W-1:0];
            ptr_q  <= PTR_W'(ptr_q + 1'b1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

FILE: rtl/core/llt_checker.sv
// Port-level checker for the lease lock table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module llt_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      done_o,
  input  logic [llt_pkg::STAT_W-1:0] status_o
);
  import llt_pkg::*;

  // An accepted transfer keeps the block busy in the following cycle.
  `ASSERT_DEF(a_accept_busy, (start && !busy) |=> busy)
  // A result only follows a busy cycle.
  `ASSERT_DEF(a_done_after_busy, done_o |-> $past(busy))
  // Busy drops exactly when the result is presented.
  `ASSERT_DEF(a_busy_fall_done, $fell(busy) |-> done_o)
  // The status is always a defined code.
  `ASSERT_DEF(a_status_code,
    done_o |-> (status_o == ST_OK || status_o == ST_NOENT || status_o == ST_BUSY))

endmodule

bind lease_lock_table_top llt_checker u_llt_checker (.*);

`default_nettype wire

FILE: bench/testbench.sv
// Testbench for the lease lock table: lock traffic checked against a predicted table.
module testbench;
  import llt_pkg::*;

  // One expected result, with the request that caused it for messages.
  typedef struct {
    op_e                 op;
    logic [CLIENT_W-1:0] client;
    logic [INDEX_W-1:0]  lock;
    logic [STAT_W-1:0]   status;
  } status_expect_t;

  // Scoreboard: keeps its own copy of the table and the queue of expected statuses.
  class lock_table_scoreboard;
    bit                  known[NUM_LOCKS];
    bit                  held[NUM_LOCKS];
    bit [CLIENT_W-1:0]   owner[NUM_LOCKS];
    bit [AGE_W-1:0]      age[NUM_LOCKS];
    bit [AGE_W-1:0]      lifetime = LIFETIME_RST;
    status_expect_t      expected_q[$];
    int unsigned         errors = 0;

    function void set_lifetime(logic [AGE_W-1:0] value);
      lifetime = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Applies an accepted request to the table and queues the status it must give.
    function void note_request(op_e op, logic [CLIENT_W-1:0] client,
                               logic [INDEX_W-1:0] lock);
      status_expect_t e;
      int             i;
      e.op     = op;
      e.client = client;
      e.lock   = lock;
      e.status = ST_OK;
      case (op)
        OP_ACQUIRE: begin
          if (lock >= NUM_LOCKS) begin
            e.status = ST_NOENT;
          end else if (known[lock] && held[lock]) begin
            e.status = ST_BUSY;
          end else begin
            known[lock] = 1'b1;
            held[lock]  = 1'b1;
            owner[lock] = client;
            age[lock]   = '0;
          end
        end
        OP_RELEASE: begin
          if (lock >= NUM_LOCKS || !known[lock]) begin
            e.status = ST_NOENT;
          end else if (owner[lock] == client) begin
            held[lock] = 1'b0;
          end
        end
        OP_HEARTBEAT: begin
          // Only the holder of a held lock refreshes its lease.
          if (lock < NUM_LOCKS && known[lock] && held[lock] && owner[lock] == client) begin
            age[lock] = '0;
          end
        end
        default: begin
          // The sweep frees expired leases and ages the others.
          for (i = 0; i < NUM_LOCKS; i++) begin
            if (known[i] && held[i]) begin
              if (age[i] >= lifetime) held[i] = 1'b0;
              else age[i] = age[i] + 1'b1;
            end
          end
        end
      endcase
      expected_q.push_back(e);
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_status(logic [STAT_W-1:0] status);
      status_expect_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual status %0d",
                 $time, status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status !== e.status) begin
          $display("%0t: status of %s client %0h lock %0d: expected %0d, actual %0d",
                   $time, e.op.name(), e.client, e.lock, e.status, status);
          errors++;
        end
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [OPC_W-1:0]    opcode_i;
  logic [CLIENT_W-1:0] client_id_i;
  logic [INDEX_W-1:0]  lock_index_i;
  logic                lease_lifetime_we_i;
  logic [AGE_W-1:0]    lease_lifetime_i;
  logic                done_o;
  logic [STAT_W-1:0]   status_o;

  lock_table_scoreboard sb = new();
  bit                   no_idle = 1'b0;
  int unsigned          stall_cycles = 0;

  lease_lock_table_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .opcode_i            (opcode_i),
    .client_id_i         (client_id_i),
    .lock_index_i        (lock_index_i),
    .lease_lifetime_we_i (lease_lifetime_we_i),
    .lease_lifetime_i    (lease_lifetime_i),
    .done_o              (done_o),
    .status_o            (status_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Every strobed result is a transfer that must match the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_status(status_o);
  end

  // Watchdog: ends the run when neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[lease_lock_table_top] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one request after a random gap and holds it until the block takes it.
  task automatic send_request(op_e op, logic [CLIENT_W-1:0] client,
                              logic [INDEX_W-1:0] lock);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    client_id_i  <= client;
    lock_index_i <= lock;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(op, client, lock);
  endtask

  // Writes the lease lifetime once the block has drained.
  task automatic write_lifetime(logic [AGE_W-1:0] value);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    lease_lifetime_we_i <= 1'b1;
    lease_lifetime_i    <= value;
    @(posedge clk_i);
    lease_lifetime_we_i <= 1'b0;
    sb.set_lifetime(value);
  endtask

  // Random traffic: a few clients fight over a few locks, with some stray requests.
  task automatic run_traffic(int count);
    logic [CLIENT_W-1:0] clients[4];
    logic [INDEX_W-1:0]  locks[6];
    logic [CLIENT_W-1:0] client;
    logic [INDEX_W-1:0]  lock;
    int unsigned         pick;
    op_e                 op;
    foreach (clients[i]) clients[i] = CLIENT_W'($urandom_range(0, 65535));
    foreach (locks[i]) locks[i] = INDEX_W'($urandom_range(0, 255));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_ACQUIRE;
      else if (pick < 65) op = OP_RELEASE;
      else if (pick < 90) op = OP_HEARTBEAT;
      else op = OP_TICK;
      client = ($urandom_range(0, 99) < 85) ? clients[$urandom_range(0, 3)]
                                            : CLIENT_W'($urandom_range(0, 65535));
      lock   = ($urandom_range(0, 99) < 80) ? locks[$urandom_range(0, 5)]
                                            : INDEX_W'($urandom_range(0, 255));
      send_request(op, client, lock);
    end
  endtask

  // Main sequence: reset, directed cases, then random phases over several lifetimes.
  initial begin
    rst_ni              <= 1'b0;
    start               <= 1'b0;
    opcode_i            <= OP_ACQUIRE;
    client_id_i         <= '0;
    lock_index_i        <= '0;
    lease_lifetime_we_i <= 1'b0;
    lease_lifetime_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unknown locks, grants, contention and releases by owner and by others.
    send_request(OP_RELEASE, 16'h0000, 8'd0);
    send_request(OP_HEARTBEAT, 16'h0000, 8'd0);
    send_request(OP_ACQUIRE, 16'h0000, 8'd0);
    send_request(OP_ACQUIRE, 16'hFFFF, 8'd255);
    send_request(OP_ACQUIRE, 16'h0001, 8'd0);
    send_request(OP_RELEASE, 16'h0001, 8'd0);
    send_request(OP_HEARTBEAT, 16'h0005, 8'd0);
    send_request(OP_HEARTBEAT, 16'hFFFF, 8'd255);
    send_request(OP_TICK, 16'hFFFF, 8'd255);
    send_request(OP_RELEASE, 16'h0000, 8'd0);
    send_request(OP_RELEASE, 16'h0000, 8'd0);
    send_request(OP_HEARTBEAT, 16'h0000, 8'd0);
    send_request(OP_ACQUIRE, 16'h5AA5, 8'd0);

    // A zero lifetime frees every held lock on the next tick.
    write_lifetime(16'd0);
    send_request(OP_TICK, 16'h0000, 8'd0);
    send_request(OP_ACQUIRE, 16'h1234, 8'd255);
    send_request(OP_ACQUIRE, 16'h0001, 8'd0);

    // A heartbeat keeps one lease alive while the other expires.
    write_lifetime(16'd1);
    send_request(OP_TICK, 16'h0000, 8'd0);
    send_request(OP_HEARTBEAT, 16'h1234, 8'd255);
    send_request(OP_TICK, 16'h0000, 8'd0);
    send_request(OP_ACQUIRE, 16'h0002, 8'd0);
    send_request(OP_ACQUIRE, 16'h0003, 8'd255);

    write_lifetime(16'hFFFF);
    send_request(OP_TICK, 16'h0000, 8'd0);

    // Random phases.
    write_lifetime(16'd2);
    run_traffic(230);
    write_lifetime(16'd0);
    run_traffic(220);
    write_lifetime(16'hFFFF);
    run_traffic(220);
    write_lifetime(16'd3);
    run_traffic(230);
    write_lifetime(AGE_W'($urandom_range(1, 8)));
    run_traffic(230);
    write_lifetime(16'd1);
    run_traffic(220);
    write_lifetime(LIFETIME_RST);
    run_traffic(230);

    // Drain the last results and allow for a late sweep.
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[lease_lock_table_top] OK");
    end else begin
      $display("[lease_lock_table_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/llt_pkg.sv
rtl/core/llt_store.sv
rtl/core/lease_lock_table_top.sv
rtl/core/llt_checker.sv
bench/testbench.sv
